>>> design/normal_map_frame_rotate_defines.svh
// Assertion macros for the normal map frame rotate block.
`ifndef NORMAL_MAP_FRAME_ROTATE_DEFINES_SVH
`define NORMAL_MAP_FRAME_ROTATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NMFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NMFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/nmfr_pkg.sv
// Shared constants for the normal map frame rotate block.
package nmfr_pkg;

    localparam int NUM_AXES = 3;

    // component order for cross products: r[i] = a[NXT1]*b[NXT2] - a[NXT2]*b[NXT1]
    localparam int NXT1 [NUM_AXES] = '{1, 2, 0};
    localparam int NXT2 [NUM_AXES] = '{2, 0, 1};

endpackage

>>> design/nmfr_norm.sv
// Pipelined vector normalizer: square sum, bit-per-stage square root and division.
module nmfr_norm
    import nmfr_pkg::*;
#(
    parameter int W      = 16,
    parameter int SIDE_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    output logic                in_rdy,
    input  logic signed [W-1:0] vec [NUM_AXES],
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_vld,
    input  logic                out_rdy,
    output logic signed [W-1:0] unit [NUM_AXES],
    output logic                zero,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int FRAC = W - 2;
    localparam int SW   = 2 * W + 2;
    localparam int RB   = W + 1;
    localparam int RW   = W + 3;
    localparam int SQ_N = W + 1;
    localparam int NW   = 2 * W - 2;
    localparam int QW   = W - 1;
    localparam int DR   = W + 2;
    localparam int DV_N = QW;
    localparam int SQ0  = 2;
    localparam int SP   = SQ0 + SQ_N;
    localparam int DV0  = SP + 1;
    localparam int SF   = DV0 + DV_N;
    localparam int NS   = SF + 1;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] ld;

    always_comb
    begin
        ld[NS-1] = !vld_reg[NS-1] || out_rdy;
        for (int i = NS - 2; i >= 0; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
        vld_next[0] = ld[0] ? in_vld : vld_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // magnitudes and squares
    logic [W-1:0]          a_m_reg    [NUM_AXES];
    logic                  a_neg_reg  [NUM_AXES];
    logic signed [2*W-1:0] a_sq_reg   [NUM_AXES];
    logic [SIDE_W-1:0]     a_side_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                a_neg_reg[i] <= vec[i][W-1];
                a_m_reg[i]   <= vec[i][W-1] ? W'(-vec[i]) : W'(vec[i]);
                a_sq_reg[i]  <= vec[i] * vec[i];
            end
            a_side_reg <= side_in;
        end
    end

    // square sum
    logic [SW-1:0]     b_s_reg;
    logic [W-1:0]      b_m_reg   [NUM_AXES];
    logic              b_neg_reg [NUM_AXES];
    logic [SIDE_W-1:0] b_side_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            b_s_reg <= SW'(unsigned'(a_sq_reg[0])) + SW'(unsigned'(a_sq_reg[1]))
                     + SW'(unsigned'(a_sq_reg[2]));
            b_m_reg    <= a_m_reg;
            b_neg_reg  <= a_neg_reg;
            b_side_reg <= a_side_reg;
        end
    end

    // square root, one result bit per stage
    logic [SW-1:0]     sq_s_reg    [SQ_N];
    logic [RW-1:0]     sq_rem_reg  [SQ_N];
    logic [RB-1:0]     sq_root_reg [SQ_N];
    logic [W-1:0]      sq_m_reg    [SQ_N][NUM_AXES];
    logic              sq_neg_reg  [SQ_N][NUM_AXES];
    logic [SIDE_W-1:0] sq_side_reg [SQ_N];

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        logic [SW-1:0]     s_src;
        logic [RW-1:0]     rem_src;
        logic [RB-1:0]     root_src;
        logic [W-1:0]      m_src   [NUM_AXES];
        logic              neg_src [NUM_AXES];
        logic [SIDE_W-1:0] side_src;
        logic [RW+1:0]     rem_sh;
        logic [RW+1:0]     trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign s_src    = b_s_reg;
            assign rem_src  = '0;
            assign root_src = '0;
            assign m_src    = b_m_reg;
            assign neg_src  = b_neg_reg;
            assign side_src = b_side_reg;
        end
        else
        begin : g_rest
            assign s_src    = sq_s_reg[k-1];
            assign rem_src  = sq_rem_reg[k-1];
            assign root_src = sq_root_reg[k-1];
            assign m_src    = sq_m_reg[k-1];
            assign neg_src  = sq_neg_reg[k-1];
            assign side_src = sq_side_reg[k-1];
        end

        assign rem_sh = {rem_src, s_src[SW-1 -: 2]};
        assign trial  = (RW+2)'({root_src, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (ld[SQ0+k])
            begin
                sq_rem_reg[k]  <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
                sq_root_reg[k] <= {root_src[RB-2:0], ge};
                sq_s_reg[k]    <= {s_src[SW-3:0], 2'b00};
                sq_m_reg[k]    <= m_src;
                sq_neg_reg[k]  <= neg_src;
                sq_side_reg[k] <= side_src;
            end
        end
    end

    // dividend setup: q = (m * 2^FRAC + L/2) / L, q fits in QW bits since m <= L
    logic [RB-1:0]     len;
    logic [NW-1:0]     num [NUM_AXES];
    logic [DR-1:0]     p_r_reg   [NUM_AXES];
    logic [QW-1:0]     p_lo_reg  [NUM_AXES];
    logic [RB-1:0]     p_len_reg;
    logic              p_zero_reg;
    logic              p_neg_reg [NUM_AXES];
    logic [SIDE_W-1:0] p_side_reg;

    assign len = sq_root_reg[SQ_N-1];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            num[i] = (NW'(sq_m_reg[SQ_N-1][i]) << FRAC) + NW'(len >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[SP])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                p_r_reg[i]  <= DR'(num[i][NW-1:QW]);
                p_lo_reg[i] <= num[i][QW-1:0];
            end
            p_len_reg  <= len;
            p_zero_reg <= (len == '0);
            p_neg_reg  <= sq_neg_reg[SQ_N-1];
            p_side_reg <= sq_side_reg[SQ_N-1];
        end
    end

    // restoring division, one quotient bit per stage
    logic [DR-1:0]     dv_r_reg    [DV_N][NUM_AXES];
    logic [QW-1:0]     dv_lo_reg   [DV_N][NUM_AXES];
    logic [QW-1:0]     dv_q_reg    [DV_N][NUM_AXES];
    logic [RB-1:0]     dv_len_reg  [DV_N];
    logic              dv_zero_reg [DV_N];
    logic              dv_neg_reg  [DV_N][NUM_AXES];
    logic [SIDE_W-1:0] dv_side_reg [DV_N];

    for (genvar j = 0; j < DV_N; j++)
    begin : g_div
        logic [DR-1:0]     r_src    [NUM_AXES];
        logic [QW-1:0]     lo_src   [NUM_AXES];
        logic [QW-1:0]     q_src    [NUM_AXES];
        logic [RB-1:0]     len_src;
        logic              zero_src;
        logic              neg_src  [NUM_AXES];
        logic [SIDE_W-1:0] side_src;
        logic [DR-1:0]     r_sh     [NUM_AXES];
        logic              ge       [NUM_AXES];

        if (j == 0)
        begin : g_first
            assign r_src    = p_r_reg;
            assign lo_src   = p_lo_reg;
            assign q_src    = '{default: '0};
            assign len_src  = p_len_reg;
            assign zero_src = p_zero_reg;
            assign neg_src  = p_neg_reg;
            assign side_src = p_side_reg;
        end
        else
        begin : g_rest
            assign r_src    = dv_r_reg[j-1];
            assign lo_src   = dv_lo_reg[j-1];
            assign q_src    = dv_q_reg[j-1];
            assign len_src  = dv_len_reg[j-1];
            assign zero_src = dv_zero_reg[j-1];
            assign neg_src  = dv_neg_reg[j-1];
            assign side_src = dv_side_reg[j-1];
        end

        always_comb
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                r_sh[i] = {r_src[i][DR-2:0], lo_src[i][QW-1]};
                ge[i]   = r_sh[i] >= DR'(len_src);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[DV0+j])
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    dv_r_reg[j][i]  <= ge[i] ? r_sh[i] - DR'(len_src) : r_sh[i];
                    dv_q_reg[j][i]  <= {q_src[i][QW-2:0], ge[i]};
                    dv_lo_reg[j][i] <= {lo_src[i][QW-2:0], 1'b0};
                end
                dv_len_reg[j]  <= len_src;
                dv_zero_reg[j] <= zero_src;
                dv_neg_reg[j]  <= neg_src;
                dv_side_reg[j] <= side_src;
            end
        end
    end

    // sign restore, zero-length force
    logic signed [W-1:0] f_u_reg [NUM_AXES];
    logic                f_zero_reg;
    logic [SIDE_W-1:0]   f_side_reg;
    logic signed [W-1:0] qmag    [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            qmag[i] = signed'(W'(dv_q_reg[DV_N-1][i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[SF])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (dv_zero_reg[DV_N-1])
                begin
                    f_u_reg[i] <= '0;
                end
                else
                begin
                    f_u_reg[i] <= dv_neg_reg[DV_N-1][i] ? -qmag[i] : qmag[i];
                end
            end
            f_zero_reg <= dv_zero_reg[DV_N-1];
            f_side_reg <= dv_side_reg[DV_N-1];
        end
    end

    assign in_rdy   = ld[0];
    assign out_vld  = vld_reg[NS-1];
    assign unit     = f_u_reg;
    assign zero     = f_zero_reg;
    assign side_out = f_side_reg;

endmodule

>>> design/normal_map_frame_rotate.sv
// Top level: tangent-space normal map rotation and frame rebuild, fully pipelined.
//
//   channel   handshake                payload
//   input     map_valid / map_stall    tangent, geo_normal, texdir, map_normal (x,y,z)
//   output    frame_valid / frame_stall new_tangent, new_bitangent, new_normal, degenerate
//
// One word per cycle while the output is not stalled. Most of the pipeline depth comes from
// the two normalizers: square root and division each take one result bit per stage.
// Every stage holds its word when the next one is full and stalled; empty stages fill,
// so input is taken while a finished word waits at the output.
// Reset clears all valid bits; data registers are not reset.
module normal_map_frame_rotate
    import nmfr_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              map_valid,
    output logic                              map_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] tangent_x,
    input  logic signed [COMPONENT_WIDTH-1:0] tangent_y,
    input  logic signed [COMPONENT_WIDTH-1:0] tangent_z,
    input  logic signed [COMPONENT_WIDTH-1:0] geo_normal_x,
    input  logic signed [COMPONENT_WIDTH-1:0] geo_normal_y,
    input  logic signed [COMPONENT_WIDTH-1:0] geo_normal_z,
    input  logic signed [COMPONENT_WIDTH-1:0] texdir_x,
    input  logic signed [COMPONENT_WIDTH-1:0] texdir_y,
    input  logic signed [COMPONENT_WIDTH-1:0] texdir_z,
    input  logic signed [COMPONENT_WIDTH-1:0] map_normal_x,
    input  logic signed [COMPONENT_WIDTH-1:0] map_normal_y,
    input  logic signed [COMPONENT_WIDTH-1:0] map_normal_z,
    output logic                              frame_valid,
    input  logic                              frame_stall,
    output logic signed [COMPONENT_WIDTH-1:0] new_tangent_x,
    output logic signed [COMPONENT_WIDTH-1:0] new_tangent_y,
    output logic signed [COMPONENT_WIDTH-1:0] new_tangent_z,
    output logic signed [COMPONENT_WIDTH-1:0] new_bitangent_x,
    output logic signed [COMPONENT_WIDTH-1:0] new_bitangent_y,
    output logic signed [COMPONENT_WIDTH-1:0] new_bitangent_z,
    output logic signed [COMPONENT_WIDTH-1:0] new_normal_x,
    output logic signed [COMPONENT_WIDTH-1:0] new_normal_y,
    output logic signed [COMPONENT_WIDTH-1:0] new_normal_z,
    output logic                              degenerate
);

    localparam int W    = COMPONENT_WIDTH;
    localparam int FRAC = W - 2;
    localparam int PW   = W + 2;
    localparam int SW   = W + 4;
    localparam int S1_W = 3 * NUM_AXES * W;
    localparam int S2_W = NUM_AXES * W + 1;

    localparam logic signed [2*W-1:0] RND  = {{(W+2){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [SW-1:0]  MAXV = {5'b00000, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0]  MINV = {5'b11111, {(W-1){1'b0}}};

    function automatic logic signed [PW-1:0] qmul(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = a * b + RND;
        return p[2*W-1:FRAC];
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v;
        if (v > MAXV)
        begin
            r = MAXV;
        end
        else if (v < MINV)
        begin
            r = MINV;
        end
        return r[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sum3(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b,
                                                 input logic signed [PW-1:0] c);
        return sat(SW'(a) + SW'(b) + SW'(c));
    endfunction

    // stage handshake
    logic [14:1] vld_reg;
    logic [14:1] vld_next;
    logic [14:1] ld;
    logic        n1_in_rdy;
    logic        n1_out_vld;
    logic        n2_in_rdy;
    logic        n2_out_vld;

    always_comb
    begin
        ld[14] = !vld_reg[14] || !frame_stall;
        ld[13] = !vld_reg[13] || ld[14];
        ld[12] = !vld_reg[12] || n2_in_rdy;
        for (int i = 11; i >= 5; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
        ld[4] = !vld_reg[4] || n1_in_rdy;
        for (int i = 3; i >= 1; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
        for (int i = 1; i <= 14; i++)
        begin
            if (!ld[i])
            begin
                vld_next[i] = vld_reg[i];
            end
            else if (i == 1)
            begin
                vld_next[i] = map_valid;
            end
            else if (i == 5)
            begin
                vld_next[i] = n1_out_vld;
            end
            else if (i == 13)
            begin
                vld_next[i] = n2_out_vld;
            end
            else
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    logic signed [W-1:0] in_t [NUM_AXES];
    logic signed [W-1:0] in_n [NUM_AXES];
    logic signed [W-1:0] in_d [NUM_AXES];
    logic signed [W-1:0] in_m [NUM_AXES];

    assign in_t = '{tangent_x, tangent_y, tangent_z};
    assign in_n = '{geo_normal_x, geo_normal_y, geo_normal_z};
    assign in_d = '{texdir_x, texdir_y, texdir_z};
    assign in_m = '{map_normal_x, map_normal_y, map_normal_z};

    // 1: N.D products
    logic signed [PW-1:0] s1_p_reg [NUM_AXES];
    logic signed [W-1:0]  s1_t_reg [NUM_AXES];
    logic signed [W-1:0]  s1_n_reg [NUM_AXES];
    logic signed [W-1:0]  s1_d_reg [NUM_AXES];
    logic signed [W-1:0]  s1_m_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s1_p_reg[i] <= qmul(in_n[i], in_d[i]);
            end
            s1_t_reg <= in_t;
            s1_n_reg <= in_n;
            s1_d_reg <= in_d;
            s1_m_reg <= in_m;
        end
    end

    // 2: dot sum
    logic signed [W-1:0] s2_dot_reg;
    logic signed [W-1:0] s2_t_reg [NUM_AXES];
    logic signed [W-1:0] s2_n_reg [NUM_AXES];
    logic signed [W-1:0] s2_d_reg [NUM_AXES];
    logic signed [W-1:0] s2_m_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            s2_dot_reg <= sum3(s1_p_reg[0], s1_p_reg[1], s1_p_reg[2]);
            s2_t_reg   <= s1_t_reg;
            s2_n_reg   <= s1_n_reg;
            s2_d_reg   <= s1_d_reg;
            s2_m_reg   <= s1_m_reg;
        end
    end

    // 3: (N.D) N
    logic signed [PW-1:0] s3_p_reg [NUM_AXES];
    logic signed [W-1:0]  s3_t_reg [NUM_AXES];
    logic signed [W-1:0]  s3_n_reg [NUM_AXES];
    logic signed [W-1:0]  s3_d_reg [NUM_AXES];
    logic signed [W-1:0]  s3_m_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s3_p_reg[i] <= qmul(s2_dot_reg, s2_n_reg[i]);
            end
            s3_t_reg <= s2_t_reg;
            s3_n_reg <= s2_n_reg;
            s3_d_reg <= s2_d_reg;
            s3_m_reg <= s2_m_reg;
        end
    end

    // 4: rejected texture direction
    logic signed [W-1:0] s4_v_reg [NUM_AXES];
    logic signed [W-1:0] s4_t_reg [NUM_AXES];
    logic signed [W-1:0] s4_n_reg [NUM_AXES];
    logic signed [W-1:0] s4_m_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s4_v_reg[i] <= sat(SW'(s3_d_reg[i]) - SW'(s3_p_reg[i]));
            end
            s4_t_reg <= s3_t_reg;
            s4_n_reg <= s3_n_reg;
            s4_m_reg <= s3_m_reg;
        end
    end

    logic [S1_W-1:0]     n1_side_in;
    logic [S1_W-1:0]     n1_side_out;
    logic signed [W-1:0] n1_u [NUM_AXES];
    logic                n1_zero;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            n1_side_in[i*W +: W]                = s4_t_reg[i];
            n1_side_in[(NUM_AXES+i)*W +: W]     = s4_n_reg[i];
            n1_side_in[(2*NUM_AXES+i)*W +: W]   = s4_m_reg[i];
        end
    end

    nmfr_norm #(
        .W      (W),
        .SIDE_W (S1_W)
    ) u_norm_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld_reg[4]),
        .in_rdy   (n1_in_rdy),
        .vec      (s4_v_reg),
        .side_in  (n1_side_in),
        .out_vld  (n1_out_vld),
        .out_rdy  (ld[5]),
        .unit     (n1_u),
        .zero     (n1_zero),
        .side_out (n1_side_out)
    );

    logic signed [W-1:0] n1_t [NUM_AXES];
    logic signed [W-1:0] n1_n [NUM_AXES];
    logic signed [W-1:0] n1_m [NUM_AXES];

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            n1_t[i] = n1_side_out[i*W +: W];
            n1_n[i] = n1_side_out[(NUM_AXES+i)*W +: W];
            n1_m[i] = n1_side_out[(2*NUM_AXES+i)*W +: W];
        end
    end

    // 5: N x U products
    logic signed [PW-1:0] s5_c0_reg [NUM_AXES];
    logic signed [PW-1:0] s5_c1_reg [NUM_AXES];
    logic signed [W-1:0]  s5_u_reg  [NUM_AXES];
    logic signed [W-1:0]  s5_n_reg  [NUM_AXES];
    logic signed [W-1:0]  s5_t_reg  [NUM_AXES];
    logic signed [W-1:0]  s5_m_reg  [NUM_AXES];
    logic                 s5_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s5_c0_reg[i] <= qmul(n1_n[NXT1[i]], n1_u[NXT2[i]]);
                s5_c1_reg[i] <= qmul(n1_n[NXT2[i]], n1_u[NXT1[i]]);
            end
            s5_u_reg   <= n1_u;
            s5_n_reg   <= n1_n;
            s5_t_reg   <= n1_t;
            s5_m_reg   <= n1_m;
            s5_bad_reg <= n1_zero;
        end
    end

    // 6: V = N x U
    logic signed [W-1:0] s6_w_reg [NUM_AXES];
    logic signed [W-1:0] s6_u_reg [NUM_AXES];
    logic signed [W-1:0] s6_n_reg [NUM_AXES];
    logic signed [W-1:0] s6_t_reg [NUM_AXES];
    logic signed [W-1:0] s6_m_reg [NUM_AXES];
    logic                s6_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s6_w_reg[i] <= sat(SW'(s5_c0_reg[i]) - SW'(s5_c1_reg[i]));
            end
            s6_u_reg   <= s5_u_reg;
            s6_n_reg   <= s5_n_reg;
            s6_t_reg   <= s5_t_reg;
            s6_m_reg   <= s5_m_reg;
            s6_bad_reg <= s5_bad_reg;
        end
    end

    // 7: basis rotation products
    logic signed [PW-1:0] s7_pu_reg [NUM_AXES];
    logic signed [PW-1:0] s7_pw_reg [NUM_AXES];
    logic signed [PW-1:0] s7_pn_reg [NUM_AXES];
    logic signed [W-1:0]  s7_t_reg  [NUM_AXES];
    logic                 s7_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s7_pu_reg[i] <= qmul(s6_u_reg[i], s6_m_reg[0]);
                s7_pw_reg[i] <= qmul(s6_w_reg[i], s6_m_reg[1]);
                s7_pn_reg[i] <= qmul(s6_n_reg[i], s6_m_reg[2]);
            end
            s7_t_reg   <= s6_t_reg;
            s7_bad_reg <= s6_bad_reg;
        end
    end

    // 8: perturbed normal
    logic signed [W-1:0] s8_n_reg [NUM_AXES];
    logic signed [W-1:0] s8_t_reg [NUM_AXES];
    logic                s8_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[8])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s8_n_reg[i] <= sum3(s7_pu_reg[i], s7_pw_reg[i], s7_pn_reg[i]);
            end
            s8_t_reg   <= s7_t_reg;
            s8_bad_reg <= s7_bad_reg;
        end
    end

    // 9: n.T products
    logic signed [PW-1:0] s9_p_reg [NUM_AXES];
    logic signed [W-1:0]  s9_n_reg [NUM_AXES];
    logic signed [W-1:0]  s9_t_reg [NUM_AXES];
    logic                 s9_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[9])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s9_p_reg[i] <= qmul(s8_n_reg[i], s8_t_reg[i]);
            end
            s9_n_reg   <= s8_n_reg;
            s9_t_reg   <= s8_t_reg;
            s9_bad_reg <= s8_bad_reg;
        end
    end

    // 10: dot sum
    logic signed [W-1:0] s10_dot_reg;
    logic signed [W-1:0] s10_n_reg [NUM_AXES];
    logic signed [W-1:0] s10_t_reg [NUM_AXES];
    logic                s10_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[10])
        begin
            s10_dot_reg <= sum3(s9_p_reg[0], s9_p_reg[1], s9_p_reg[2]);
            s10_n_reg   <= s9_n_reg;
            s10_t_reg   <= s9_t_reg;
            s10_bad_reg <= s9_bad_reg;
        end
    end

    // 11: (n.T) n
    logic signed [PW-1:0] s11_p_reg [NUM_AXES];
    logic signed [W-1:0]  s11_n_reg [NUM_AXES];
    logic signed [W-1:0]  s11_t_reg [NUM_AXES];
    logic                 s11_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[11])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s11_p_reg[i] <= qmul(s10_dot_reg, s10_n_reg[i]);
            end
            s11_n_reg   <= s10_n_reg;
            s11_t_reg   <= s10_t_reg;
            s11_bad_reg <= s10_bad_reg;
        end
    end

    // 12: rejected tangent
    logic signed [W-1:0] s12_v_reg [NUM_AXES];
    logic signed [W-1:0] s12_n_reg [NUM_AXES];
    logic                s12_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[12])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s12_v_reg[i] <= sat(SW'(s11_t_reg[i]) - SW'(s11_p_reg[i]));
            end
            s12_n_reg   <= s11_n_reg;
            s12_bad_reg <= s11_bad_reg;
        end
    end

    logic [S2_W-1:0]     n2_side_in;
    logic [S2_W-1:0]     n2_side_out;
    logic signed [W-1:0] n2_t [NUM_AXES];
    logic signed [W-1:0] n2_n [NUM_AXES];
    logic                n2_zero;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            n2_side_in[i*W +: W] = s12_n_reg[i];
            n2_n[i]              = n2_side_out[i*W +: W];
        end
        n2_side_in[S2_W-1] = s12_bad_reg;
    end

    nmfr_norm #(
        .W      (W),
        .SIDE_W (S2_W)
    ) u_norm_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld_reg[12]),
        .in_rdy   (n2_in_rdy),
        .vec      (s12_v_reg),
        .side_in  (n2_side_in),
        .out_vld  (n2_out_vld),
        .out_rdy  (ld[13]),
        .unit     (n2_t),
        .zero     (n2_zero),
        .side_out (n2_side_out)
    );

    // 13: n x t products
    logic signed [PW-1:0] s13_c0_reg [NUM_AXES];
    logic signed [PW-1:0] s13_c1_reg [NUM_AXES];
    logic signed [W-1:0]  s13_n_reg  [NUM_AXES];
    logic signed [W-1:0]  s13_t_reg  [NUM_AXES];
    logic                 s13_bad_reg;

    always_ff @(posedge clk)
    begin
        if (ld[13])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                s13_c0_reg[i] <= qmul(n2_n[NXT1[i]], n2_t[NXT2[i]]);
                s13_c1_reg[i] <= qmul(n2_n[NXT2[i]], n2_t[NXT1[i]]);
            end
            s13_n_reg   <= n2_n;
            s13_t_reg   <= n2_t;
            s13_bad_reg <= n2_zero || n2_side_out[S2_W-1];
        end
    end

    // 14: output word
    logic signed [W-1:0] o_t_reg [NUM_AXES];
    logic signed [W-1:0] o_b_reg [NUM_AXES];
    logic signed [W-1:0] o_n_reg [NUM_AXES];
    logic                o_deg_reg;

    always_ff @(posedge clk)
    begin
        if (ld[14])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (s13_bad_reg)
                begin
                    o_t_reg[i] <= '0;
                    o_b_reg[i] <= '0;
                    o_n_reg[i] <= '0;
                end
                else
                begin
                    o_t_reg[i] <= s13_t_reg[i];
                    o_b_reg[i] <= sat(SW'(s13_c0_reg[i]) - SW'(s13_c1_reg[i]));
                    o_n_reg[i] <= s13_n_reg[i];
                end
            end
            o_deg_reg <= s13_bad_reg;
        end
    end

    assign map_stall       = !ld[1];
    assign frame_valid     = vld_reg[14];
    assign new_tangent_x   = o_t_reg[0];
    assign new_tangent_y   = o_t_reg[1];
    assign new_tangent_z   = o_t_reg[2];
    assign new_bitangent_x = o_b_reg[0];
    assign new_bitangent_y = o_b_reg[1];
    assign new_bitangent_z = o_b_reg[2];
    assign new_normal_x    = o_n_reg[0];
    assign new_normal_y    = o_n_reg[1];
    assign new_normal_z    = o_n_reg[2];
    assign degenerate      = o_deg_reg;

endmodule

>>> design/nmfr_chk.sv
// Port checker for the normal map frame rotate block, with its bind.
`include "normal_map_frame_rotate_defines.svh"

module nmfr_chk
#(
    parameter int COMPONENT_WIDTH = 16
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              frame_valid,
    input logic                              frame_stall,
    input logic signed [COMPONENT_WIDTH-1:0] new_tangent_x,
    input logic signed [COMPONENT_WIDTH-1:0] new_tangent_y,
    input logic signed [COMPONENT_WIDTH-1:0] new_tangent_z,
    input logic signed [COMPONENT_WIDTH-1:0] new_bitangent_x,
    input logic signed [COMPONENT_WIDTH-1:0] new_bitangent_y,
    input logic signed [COMPONENT_WIDTH-1:0] new_bitangent_z,
    input logic signed [COMPONENT_WIDTH-1:0] new_normal_x,
    input logic signed [COMPONENT_WIDTH-1:0] new_normal_y,
    input logic signed [COMPONENT_WIDTH-1:0] new_normal_z,
    input logic                              degenerate
);

    logic                           all_zero;
    logic                           tan_nonzero;
    logic [9*COMPONENT_WIDTH:0]     word_bits;

    assign all_zero = new_tangent_x == 0 && new_tangent_y == 0 && new_tangent_z == 0
                   && new_bitangent_x == 0 && new_bitangent_y == 0 && new_bitangent_z == 0
                   && new_normal_x == 0 && new_normal_y == 0 && new_normal_z == 0;

    assign tan_nonzero = new_tangent_x != 0 || new_tangent_y != 0 || new_tangent_z != 0;

    assign word_bits = {new_tangent_x, new_tangent_y, new_tangent_z,
                        new_bitangent_x, new_bitangent_y, new_bitangent_z,
                        new_normal_x, new_normal_y, new_normal_z, degenerate};

    `NMFR_ASSERT_NEXT(a_out_hold, frame_valid && frame_stall, frame_valid, "output word dropped")
    `NMFR_ASSERT_NEXT(a_out_stable, frame_valid && frame_stall, $stable(word_bits), "stalled word changed")
    `NMFR_ASSERT_NOW(a_deg_zero, frame_valid && degenerate, all_zero, "degenerate word not zero")
    `NMFR_ASSERT_NOW(a_unit_tangent, frame_valid && !degenerate, tan_nonzero, "unit tangent is zero")

endmodule

bind normal_map_frame_rotate nmfr_chk #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_nmfr_chk (.*);

>>> dv/normal_map_frame_rotate_test.sv
// Testbench for normal_map_frame_rotate: random and directed frames checked against a frame predictor.
`timescale 1ns / 100ps

module normal_map_frame_rotate_test;

    localparam int W = 16;
    localparam int FRAC = W - 2;
    localparam longint CMAX = (64'sd1 <<< (W - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    typedef logic signed [W-1:0] comp_t;
    typedef struct packed {
        comp_t [2:0] tan;
        comp_t [2:0] nrm;
        comp_t [2:0] dir;
        comp_t [2:0] map;
    } frame_in_t;
    typedef struct packed {
        comp_t [2:0] tan;
        comp_t [2:0] bit_t;
        comp_t [2:0] nrm;
        logic        degen;
    } frame_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic map_valid = 1'b0;
    logic map_stall;
    logic frame_valid;
    logic frame_stall = 1'b0;
    frame_in_t drv = '0;
    frame_out_t got;

    frame_in_t pending_words[$];
    frame_out_t expected_frames[$];
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    bit hold_until_drained = 1'b0;

    normal_map_frame_rotate #(.COMPONENT_WIDTH(W)) DUT (
        .clk(clk), .rst_n(rst_n),
        .map_valid(map_valid), .map_stall(map_stall),
        .tangent_x(drv.tan[0]), .tangent_y(drv.tan[1]), .tangent_z(drv.tan[2]),
        .geo_normal_x(drv.nrm[0]), .geo_normal_y(drv.nrm[1]), .geo_normal_z(drv.nrm[2]),
        .texdir_x(drv.dir[0]), .texdir_y(drv.dir[1]), .texdir_z(drv.dir[2]),
        .map_normal_x(drv.map[0]), .map_normal_y(drv.map[1]), .map_normal_z(drv.map[2]),
        .frame_valid(frame_valid), .frame_stall(frame_stall),
        .new_tangent_x(got.tan[0]), .new_tangent_y(got.tan[1]), .new_tangent_z(got.tan[2]),
        .new_bitangent_x(got.bit_t[0]), .new_bitangent_y(got.bit_t[1]),
        .new_bitangent_z(got.bit_t[2]),
        .new_normal_x(got.nrm[0]), .new_normal_y(got.nrm[1]), .new_normal_z(got.nrm[2]),
        .degenerate(got.degen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint fx_dot(longint a[3], longint b[3]);
        return clamp(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]));
    endfunction

    function automatic void fx_cross(longint a[3], longint b[3], output longint r[3]);
        for (int i = 0; i < 3; i++)
            r[i] = clamp(fx_mul(a[(i+1)%3], b[(i+2)%3]) - fx_mul(a[(i+2)%3], b[(i+1)%3]));
    endfunction

    function automatic void fx_reject(longint v[3], longint n[3], output longint r[3]);
        longint d;
        d = fx_dot(n, v);
        for (int i = 0; i < 3; i++)
            r[i] = clamp(v[i] - fx_mul(d, n[i]));
    endfunction

    function automatic bit fx_normalize(longint v[3], output longint r[3]);
        longint unsigned s, len, m, q;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            m = v[i] < 0 ? -v[i] : v[i];
            s += m * m;
        end
        len = 0;
        for (int b = 31; b >= 0; b--)
            if ((len | (64'd1 << b)) * (len | (64'd1 << b)) <= s)
                len |= 64'd1 << b;
        if (len == 0)
        begin
            r = '{0, 0, 0};
            return 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            m = v[i] < 0 ? -v[i] : v[i];
            q = ((m << FRAC) + len / 2) / len;
            if (q > CMAX + 1) q = CMAX + 1;
            r[i] = clamp(v[i] < 0 ? -longint'(q) : longint'(q));
        end
        return 1'b1;
    endfunction

    function automatic frame_out_t rotate_frame(frame_in_t w);
        longint tn[3], nr[3], dr[3], mp[3], u[3], v[3], bv[3], n[3], t[3], b[3];
        bit ok;
        frame_out_t r;
        for (int i = 0; i < 3; i++)
        begin
            tn[i] = w.tan[i]; nr[i] = w.nrm[i]; dr[i] = w.dir[i]; mp[i] = w.map[i];
        end
        fx_reject(dr, nr, v);
        ok = fx_normalize(v, u);
        fx_cross(nr, u, bv);
        for (int i = 0; i < 3; i++)
            n[i] = clamp(fx_mul(u[i], mp[0]) + fx_mul(bv[i], mp[1]) + fx_mul(nr[i], mp[2]));
        fx_reject(tn, n, v);
        if (!fx_normalize(v, t)) ok = 1'b0;
        fx_cross(n, t, b);
        for (int i = 0; i < 3; i++)
        begin
            r.tan[i] = ok ? comp_t'(t[i]) : '0;
            r.bit_t[i] = ok ? comp_t'(b[i]) : '0;
            r.nrm[i] = ok ? comp_t'(n[i]) : '0;
        end
        r.degen = !ok;
        return r;
    endfunction

    function automatic comp_t rand_comp(int mode);
        case (mode)
            0: return comp_t'($urandom);
            1: return comp_t'($urandom_range(0, 32768) - 16384);
            default: return comp_t'($urandom_range(0, 512) - 256);
        endcase
    endfunction

    function automatic frame_in_t rand_word();
        frame_in_t w;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            w.tan[i] = rand_comp(mode < 2 ? 0 : 1);
            w.nrm[i] = rand_comp(mode < 2 ? 0 : (mode == 2 ? 2 : 1));
            w.dir[i] = rand_comp(mode < 2 ? 0 : 1);
            w.map[i] = rand_comp(mode < 2 ? 0 : 1);
        end
        if (mode >= 4)
        begin
            // axis-aligned unit normal, map normal z component between 12000 and 16384
            w.nrm = '0;
            w.nrm[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16384 : -16384;
            w.map[2] = comp_t'($urandom_range(12000, 16384));
        end
        return w;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n && !(map_valid && map_stall))
        begin
            if (map_valid)
                void'(pending_words.pop_front());
            if (hold_until_drained && expected_frames.size() == 0
                && !(map_valid && !map_stall))
                hold_until_drained <= 1'b0;
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                map_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 && !hold_until_drained)
            begin
                map_valid <= 1'b1;
                drv <= pending_words[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                map_valid <= 1'b0;
        end
    end

    always @(posedge clk)
        if (rst_n && map_valid && !map_stall)
            expected_frames = {expected_frames, rotate_frame(drv)};

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && frame_valid && !frame_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                frame_out_t e;
                e = expected_frames.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (got.tan[i] !== e.tan[i])
                    begin
                        $display("%0t: new_tangent[%0d] exp %0d got %0d",
                                 $time, i, e.tan[i], got.tan[i]);
                        errors++;
                    end
                    if (got.bit_t[i] !== e.bit_t[i])
                    begin
                        $display("%0t: new_bitangent[%0d] exp %0d got %0d",
                                 $time, i, e.bit_t[i], got.bit_t[i]);
                        errors++;
                    end
                    if (got.nrm[i] !== e.nrm[i])
                    begin
                        $display("%0t: new_normal[%0d] exp %0d got %0d",
                                 $time, i, e.nrm[i], got.nrm[i]);
                        errors++;
                    end
                end
                if (got.degen !== e.degen)
                begin
                    $display("%0t: degenerate exp %0b got %0b", $time, e.degen, got.degen);
                    errors++;
                end
            end
        end
        stall_phase <= stall_phase + 1;
        frame_stall <= (stall_phase % 400 < 120) ? 1'b0
                     : ((stall_phase / 7) % 3 == 0) || ($urandom_range(0, 4) == 0);
    end

    initial
    begin
        frame_in_t w;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // directed: unit frame, extremes, zero vectors, D parallel to N
        w = '0;
        w.tan[0] = 16384; w.nrm[2] = 16384; w.dir[0] = 16384; w.map[2] = 16384;
        pending_words = {pending_words, w};
        w.map[0] = 16384; w.map[2] = 0;
        pending_words = {pending_words, w};
        w.map[1] = -16384;
        pending_words = {pending_words, w};
        w = '0;
        pending_words = {pending_words, w};
        w.nrm[2] = 16384; w.dir[2] = 16384; w.tan[0] = 16384; w.map[2] = 16384;
        pending_words = {pending_words, w};
        w.dir[2] = 0; w.dir[1] = 100; w.tan = '0;
        pending_words = {pending_words, w};
        w.tan[2] = 5000; w.map = '0;
        pending_words = {pending_words, w};
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w.tan[i] = (k & 1) ? -32768 : 32767;
                w.nrm[i] = (k & 2) ? -32768 : 32767;
                w.dir[i] = (k == 1) ? 32767 : -32768;
                w.map[i] = (k & 1) ? 32767 : -32768;
            end
            pending_words = {pending_words, w};
        end
        w = '1;
        pending_words = {pending_words, w};
        w = '0;
        w.nrm[0] = 1; w.dir[1] = 1; w.tan[2] = 1; w.map[0] = 1;
        pending_words = {pending_words, w};
        w.nrm[0] = -16384; w.dir[1] = -16384; w.tan[2] = -16384;
        w.map = '0; w.map[2] = -16384;
        pending_words = {pending_words, w};
        for (int k = 0; k < 225; k++)
            pending_words = {pending_words, rand_word()};
        wait (pending_words.size() == 0);
        hold_until_drained <= 1'b1;
        for (int k = 0; k < 225; k++)
            pending_words = {pending_words, rand_word()};
        wait (pending_words.size() == 0 && expected_frames.size() == 0 && !map_valid);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
